[hw/rtl/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus RTU reply checker package
// Shared types, constants and the CRC-16 byte update for the reply checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int unsigned CNT_W      = 5;
    localparam logic [CNT_W-1:0] MAX_FRAME = CNT_W'(30);
    localparam int unsigned HDR_DEPTH  = 3;
    localparam int unsigned PAY_DEPTH  = 4;

    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  FUNC_READ  = 8'h03;
    localparam logic [7:0]  FUNC_LIMIT = 8'h80;
    localparam logic [7:0]  CNT_ONE_WORD  = 8'd2;
    localparam logic [7:0]  CNT_TWO_WORDS = 8'd4;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;
    localparam logic       READ_MODE_RESET      = 1'b1;

    typedef enum logic [1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_READ_MODE      = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_CRC   = 3'd1,
        ST_ADDR  = 3'd2,
        ST_FUNC  = 3'd3,
        ST_SHORT = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] value;
        logic               value_updated;
        logic [CNT_W-1:0]   frame_length;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic       read_mode;
    } cfg_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/mrc_frame.sv]
// ----------------------------------------------------------------------------
// Reply frame tracker
// Keeps the running CRC, header and payload bytes of the current frame and
// forms the check result when the last beat of a frame arrives.
// ----------------------------------------------------------------------------
module mrc_frame
    import mrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_beat_t  beat,
    input  cfg_t      cfg,
    output logic      push,
    output out_beat_t result
);

    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [7:0]       recent_reg [2];
    logic [7:0]       recent_next [2];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       hdr_reg [HDR_DEPTH];
    logic [7:0]       hdr_next [HDR_DEPTH];
    logic [7:0]       pay_reg [PAY_DEPTH];
    logic [7:0]       pay_next [PAY_DEPTH];
    logic [8:0]       needed_len;

    always_comb
    begin
        crc_next    = crc_reg;
        recent_next = recent_reg;
        count_next  = count_reg;
        hdr_next    = hdr_reg;
        pay_next    = pay_reg;
        if (count_reg < MAX_FRAME)
        begin
            if (count_reg >= CNT_W'(2))
            begin
                crc_next = crc_fold(crc_reg, recent_reg[0]);
            end
            recent_next[0] = recent_reg[1];
            recent_next[1] = beat.data_byte;
            for (int i = 0; i < HDR_DEPTH; i++)
            begin
                if (count_reg == CNT_W'(i))
                begin
                    hdr_next[i] = beat.data_byte;
                end
            end
            for (int i = 0; i < PAY_DEPTH; i++)
            begin
                if (count_reg == CNT_W'(i + HDR_DEPTH))
                begin
                    pay_next[i] = beat.data_byte;
                end
            end
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign needed_len = {1'b0, hdr_next[2]} + 9'd3;

    always_comb
    begin
        result.status        = ST_OK;
        result.value         = '0;
        result.value_updated = 1'b0;
        result.frame_length  = count_next;
        if ((count_next < CNT_W'(3)) || (recent_next[0] != crc_next[7:0]) ||
            (recent_next[1] != crc_next[15:8]))
        begin
            result.status = ST_CRC;
        end
        else if (hdr_next[0] != cfg.device_address)
        begin
            result.status = ST_ADDR;
        end
        else if (cfg.read_mode)
        begin
            if (hdr_next[1] != FUNC_READ)
            begin
                result.status = ST_FUNC;
            end
            else if ({4'b0, count_next} < needed_len)
            begin
                result.status = ST_SHORT;
            end
            else if (hdr_next[2] == CNT_TWO_WORDS)
            begin
                result.value = {pay_next[2], pay_next[3], pay_next[0], pay_next[1]};
                result.value_updated = 1'b1;
            end
            else if (hdr_next[2] == CNT_ONE_WORD)
            begin
                result.value = {16'h0000, pay_next[0], pay_next[1]};
                result.value_updated = 1'b1;
            end
        end
        else if (hdr_next[1] >= FUNC_LIMIT)
        begin
            result.status = ST_FUNC;
        end
    end

    assign push = fire && beat.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            for (int i = 0; i < 2; i++)
            begin
                recent_reg[i] <= '0;
            end
            for (int i = 0; i < HDR_DEPTH; i++)
            begin
                hdr_reg[i] <= '0;
            end
            for (int i = 0; i < PAY_DEPTH; i++)
            begin
                pay_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            if (beat.last)
            begin
                crc_reg   <= CRC_INIT;
                count_reg <= '0;
                for (int i = 0; i < 2; i++)
                begin
                    recent_reg[i] <= '0;
                end
                for (int i = 0; i < HDR_DEPTH; i++)
                begin
                    hdr_reg[i] <= '0;
                end
                for (int i = 0; i < PAY_DEPTH; i++)
                begin
                    pay_reg[i] <= '0;
                end
            end
            else
            begin
                crc_reg    <= crc_next;
                count_reg  <= count_next;
                recent_reg <= recent_next;
                hdr_reg    <= hdr_next;
                pay_reg    <= pay_next;
            end
        end
    end

endmodule

[hw/rtl/mrc_out_buf.sv]
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid stage, so a result can be taken in while the
// previous one still waits at the output.
// ----------------------------------------------------------------------------
module mrc_out_buf
    import mrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_beat_t push_data,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_beat_t out_data_reg;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_beat_t skid_data_reg;
    logic      pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= push_data;
            end
            else
            begin
                skid_data_reg <= push_data;
            end
        end
    end

endmodule

[hw/rtl/modbus_rtu_reply_checker.sv]
// ----------------------------------------------------------------------------
// Modbus RTU reply checker
// Checks CRC, address, function code and byte count of reply frames and
// extracts up to two register words from a good read reply.
// ----------------------------------------------------------------------------
// The checker takes one reply byte per clock cycle with no gaps required
// while the result buffer has space, and gives one result per frame: the
// beat that carries the last mark passes the input register, then the CRC
// byte update and frame checks into the result register. A skid stage behind
// the result register keeps input beats flowing for one stalled result.
// Configuration writes complete in the cycle they are presented.
module modbus_rtu_reply_checker
    import mrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_beat_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_beat_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  logic [7:0] cfg_data
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    in_beat_t s1_beat_reg;
    logic     s1_fire;
    logic     space;
    logic     push;
    out_beat_t result;
    cfg_t     cfg_reg;

    assign s1_fire   = s1_valid_reg && space;
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_beat_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RESET;
            cfg_reg.read_mode      <= READ_MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                CFG_READ_MODE:      cfg_reg.read_mode      <= cfg_data[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    mrc_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .beat   (s1_beat_reg),
        .cfg    (cfg_reg),
        .push   (push),
        .result (result)
    );

    mrc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[hw/rtl/mrc_checker.sv]
// ----------------------------------------------------------------------------
// Reply checker port assertions
// Checks result handshake behavior and result consistency at the top ports.
// ----------------------------------------------------------------------------
module mrc_checker
    import mrc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result beat dropped before it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("Stalled result beat changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.value_updated |-> out_data.status == ST_OK)
        else $error("Value updated on a failed reply.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.value_updated |-> out_data.value == '0)
        else $error("Value not zero without an update.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_length < CNT_W'(3) |-> out_data.status == ST_CRC)
        else $error("Frame under three bytes not flagged.");

endmodule

bind modbus_rtu_reply_checker mrc_checker u_mrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
